### src/emqd_pkg.sv
// Package for the exponential-mean quasi-difference core.
// Holds constants, register indexes and the queue entry type. No dependencies.
package emqd_pkg;
   localparam int MaxCovariatesDef = 4;
   localparam int FracBitsDef      = 16;
   localparam int NumCoef          = 4;
   localparam logic [15:0] FirstPeriod = 16'd2;
   localparam logic signed [32:0] Log2eQ30 = 33'sd1549082005;
   localparam logic [29:0] Ln2Q30 = 30'd744261118;
   localparam logic [30:0] OneQ30 = 31'd1073741824;
   localparam int ExpTerms = 12;

   localparam logic [2:0] RegFeedback = 3'd0;
   localparam logic [2:0] RegCoefA    = 3'd1;
   localparam logic [2:0] RegCoefB    = 3'd2;
   localparam logic [2:0] RegCoefC    = 3'd3;
   localparam logic [2:0] RegCoefD    = 3'd4;
   localparam logic [2:0] RegCovUsed  = 3'd5;

   // Classified item handed from front to back.
   typedef struct packed {
      logic signed [38:0] index;   // clamped linear index
      logic signed [31:0] outcome;
      logic signed [31:0] lagged;
      logic               diff_valid;
   } item_type;
endpackage

### src/emqd_if.sv
// Valid/ready channel interface carrying a payload of a given type.
// Depends on nothing.
interface emqd_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### src/emqd_front.sv
// Front end: accepts observations and forms the linear index one covariate a beat-cycle.
// Depends on emqd_pkg.
module emqd_front import emqd_pkg::*; #(
   parameter int MAX_COVARIATES = MaxCovariatesDef,
   parameter int FRAC_BITS = FracBitsDef
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [15:0] in_period,
   input  logic signed [31:0] in_outcome,
   input  logic signed [31:0] in_lagged,
   input  logic [NumCoef-1:0][31:0] in_cov,
   input  logic [NumCoef-1:0][31:0] coef,
   input  logic [2:0] cov_used,
   output logic q_valid,
   input  logic q_ready,
   output item_type q_item
);
   localparam logic signed [57:0] Lim = 58'sd32 <<< FRAC_BITS;
   localparam logic [2:0] MaxUsed =
      (MAX_COVARIATES < NumCoef) ? 3'(MAX_COVARIATES) : 3'(NumCoef);

   logic busy_ff, busy_in, done_ff, done_in;
   logic [2:0] k_ff, k_in, used_ff, used_in;
   logic [NumCoef-1:0][31:0] cov_ff, cov_in;
   logic signed [57:0] acc_ff, acc_in;
   logic signed [31:0] y_ff, y_in, ly_ff, ly_in;
   logic dv_ff, dv_in;
   logic signed [63:0] prod;
   logic signed [57:0] clamped;

   assign in_ready = !busy_ff && !done_ff;
   assign prod = $signed(coef[k_ff[1:0]]) * $signed(cov_ff[k_ff[1:0]]);
   assign clamped = (acc_ff > Lim) ? Lim : (acc_ff < -Lim) ? -Lim : acc_ff;
   assign q_valid = done_ff;
   assign q_item = '{index: 39'(clamped), outcome: y_ff, lagged: ly_ff, diff_valid: dv_ff};

   always_comb begin
      busy_in = busy_ff; done_in = done_ff; k_in = k_ff; used_in = used_ff;
      cov_in = cov_ff; acc_in = acc_ff; y_in = y_ff; ly_in = ly_ff; dv_in = dv_ff;
      if (in_valid && in_ready) begin
         busy_in = 1'b1; k_in = '0; acc_in = '0;
         used_in = (cov_used > MaxUsed) ? MaxUsed : cov_used;
         cov_in = in_cov; y_in = in_outcome; ly_in = in_lagged;
         dv_in = in_period > FirstPeriod;
      end else if (busy_ff) begin
         if (k_ff >= used_ff) begin
            busy_in = 1'b0; done_in = 1'b1;
         end else begin
            // arithmetic shift floors toward minus infinity
            acc_in = acc_ff + 58'(prod >>> FRAC_BITS);
            k_in = k_ff + 3'd1;
         end
      end else if (done_ff && q_ready) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; k_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; k_ff <= k_in;
      end
      used_ff <= used_in; cov_ff <= cov_in; acc_ff <= acc_in;
      y_ff <= y_in; ly_ff <= ly_in; dv_ff <= dv_in;
   end

`ifndef NO_ASSERTIONS
   a_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> k_ff <= 3'(NumCoef)) else $error("index step overran");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff)) else $error("front busy and done at once");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      done_ff && !q_ready |=> done_ff) else $error("queued item dropped");
`endif
endmodule

### src/emqd_queue.sv
// Two-entry queue between front and back ends.
// Depends on emqd_pkg.
module emqd_queue import emqd_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  item_type in_item,
   output logic out_valid,
   input  logic out_ready,
   output item_type out_item
);
   item_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;
   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_item = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wp_ff] <= in_item;
   end
`ifndef NO_ASSERTIONS
   a_occ: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("queue occupancy out of range");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) |-> (wp_ff != rp_ff)) else $error("queue pointers disagree");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("push lost");
`endif
endmodule

### src/emqd_back.sv
// Back end: exponential series, quasi-difference products and a restoring divider.
// Depends on emqd_pkg.
module emqd_back import emqd_pkg::*; #(
   parameter int FRAC_BITS = FracBitsDef
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  item_type in_item,
   input  logic signed [31:0] rho,
   output logic out_valid,
   input  logic out_ready,
   output logic [31:0] out_mu,
   output logic signed [31:0] out_q,
   output logic out_dv,
   output logic out_sat
);
   localparam int SBase = FRAC_BITS - 30;
   localparam logic [62:0] Cap = 63'd1 << 62;

   typedef enum logic [3:0] {
      S_IDLE, S_LOG, S_FRAC, S_SERIES, S_TERM, S_SCALE, S_AB, S_MUL, S_MUL2, S_DIV,
      S_FIN, S_OUT
   } state_type;
   state_type st_ff;

   item_type it_ff;
   logic signed [71:0] y_ff;
   logic [29:0] r_ff;
   logic [31:0] term_ff;
   logic [29:0] v_ff;
   logic [34:0] e_ff;
   logic [3:0] k_ff;
   logic [31:0] mu_ff, pmu_ff, plag_ff;
   logic signed [56:0] a_ff, b_ff;
   logic [95:0] num_ff;       // |a| * prev_mu
   logic [95:0] quo_ff;
   logic [32:0] rem_ff;
   logic [6:0] cnt_ff;
   logic sat_ff;
   logic [31:0] res_mu_ff, res_q_ff;
   logic res_dv_ff, res_sat_ff;

   logic signed [71:0] n_full;
   logic signed [15:0] s_val;
   logic [61:0] tprod;
   logic [34:0] recip_k;
   logic [63:0] qprod;
   logic [29:0] quot;
   logic [33:0] rem_sh;
   logic [95:0] q_sel;
   logic signed [64:0] pa, pb;
   logic signed [63:0] term_s;
   logic signed [64:0] q_full;
   logic q_ovf;
   logic [56:0] mag;
   logic [31:0] div_d;
   logic [63:0] e_wide;

   // ceil(2^34 / k): exact floor division of a 30-bit value by k = 1..12
   function automatic logic [34:0] recip(input logic [3:0] k);
      case (k)
         4'd1:    return 35'd17179869184;
         4'd2:    return 35'd8589934592;
         4'd3:    return 35'd5726623062;
         4'd4:    return 35'd4294967296;
         4'd5:    return 35'd3435973837;
         4'd6:    return 35'd2863311531;
         4'd7:    return 35'd2454267027;
         4'd8:    return 35'd2147483648;
         4'd9:    return 35'd1908874354;
         4'd10:   return 35'd1717986919;
         4'd11:   return 35'd1561806290;
         4'd12:   return 35'd1431655766;
         default: return 35'd17179869184;
      endcase
   endfunction

   assign n_full = y_ff >>> (FRAC_BITS + 30);
   assign s_val = 16'(n_full) + 16'(SBase);
   assign tprod = 62'(term_ff) * 62'(r_ff);
   assign recip_k = recip(k_ff);
   assign qprod = 64'(v_ff) * 64'(recip_k);
   assign quot = 30'(qprod >> 34);
   assign div_d = (mu_ff == '0) ? 32'd1 : mu_ff;
   assign rem_sh = {rem_ff, num_ff[95]};
   assign q_sel = quo_ff;
   assign e_wide = 64'(e_ff);
   assign mag = (a_ff < 0) ? 57'(-a_ff) : 57'(a_ff);
   assign term_s = (quo_ff[95:62] != '0) ? $signed({1'b0, Cap})
                   : $signed({1'b0, quo_ff[62:0]});
   assign q_full = (a_ff < 0 ? -65'(term_s) : 65'(term_s)) - 65'(b_ff);
   assign q_ovf = (q_full > 65'sd2147483647) || (q_full < -65'sd2147483648);
   assign pa = 65'($signed(it_ff.outcome)) * (65'sd1 <<< FRAC_BITS)
               - 65'(rho) * 65'(it_ff.lagged);
   assign pb = 65'($signed(it_ff.lagged)) * (65'sd1 <<< FRAC_BITS)
               - 65'(rho) * 65'($signed(plag_ff));

   assign in_ready = st_ff == S_IDLE;
   assign out_valid = st_ff == S_OUT;
   assign out_mu = res_mu_ff;
   assign out_q = res_q_ff;
   assign out_dv = res_dv_ff;
   assign out_sat = res_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; pmu_ff <= '0; plag_ff <= '0;
      end else begin
         case (st_ff)
            S_IDLE: if (in_valid) begin
               it_ff <= in_item; st_ff <= S_LOG; sat_ff <= 1'b0;
            end
            S_LOG: begin
               y_ff <= 72'(it_ff.index) * 72'(Log2eQ30);
               st_ff <= S_FRAC;
            end
            S_FRAC: begin
               // fraction in Q30 times ln2
               r_ff <= 30'((64'(y_ff[FRAC_BITS+29:FRAC_BITS]) * 64'(Ln2Q30)) >> 30);
               term_ff <= 32'(OneQ30); e_ff <= 35'(OneQ30); k_ff <= 4'd1;
               st_ff <= S_SERIES;
            end
            S_SERIES: begin
               v_ff <= 30'(tprod >> 30);
               st_ff <= S_TERM;
            end
            S_TERM: begin
               // divide by k through the reciprocal table
               term_ff <= 32'(quot);
               e_ff <= e_ff + 35'(quot);
               k_ff <= k_ff + 4'd1;
               st_ff <= (k_ff == 4'(ExpTerms)) ? S_SCALE : S_SERIES;
            end
            S_SCALE: begin
               if (s_val >= 0) begin
                  if (s_val > 16'sd32 || (e_wide << s_val) > 64'hFFFF_FFFF) begin
                     mu_ff <= '1; sat_ff <= 1'b1;
                  end else mu_ff <= 32'(e_wide << s_val);
               end else if (-s_val >= 16'sd63) mu_ff <= '0;
               else mu_ff <= 32'(e_wide >> (-s_val));
               st_ff <= S_AB;
            end
            S_AB: begin
               a_ff <= 57'(pa >>> FRAC_BITS);
               b_ff <= 57'(pb >>> FRAC_BITS);
               st_ff <= it_ff.diff_valid ? S_MUL : S_FIN;
            end
            S_MUL: begin
               // low half of |a| first, high half added next cycle
               num_ff <= 96'(mag[31:0]) * 96'(pmu_ff);
               rem_ff <= '0; quo_ff <= '0; cnt_ff <= '0;
               st_ff <= S_MUL2;
            end
            S_MUL2: begin
               num_ff <= num_ff + {64'(mag[56:32]) * 64'(pmu_ff), 32'd0};
               st_ff <= S_DIV;
            end
            S_DIV: begin
               // restoring division, one quotient bit a cycle
               if (rem_sh >= {2'b0, div_d}) begin
                  rem_ff <= 33'(rem_sh - {2'b0, div_d}); quo_ff <= {q_sel[94:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh[32:0]; quo_ff <= {q_sel[94:0], 1'b0};
               end
               num_ff <= num_ff << 1;
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd95) st_ff <= S_FIN;
            end
            S_FIN: begin
               res_mu_ff <= mu_ff; res_dv_ff <= it_ff.diff_valid;
               res_sat_ff <= sat_ff || (it_ff.diff_valid && q_ovf);
               if (!it_ff.diff_valid) res_q_ff <= '0;
               else if (q_full > 65'sd2147483647) res_q_ff <= 32'h7FFF_FFFF;
               else if (q_full < -65'sd2147483648) res_q_ff <= 32'h8000_0000;
               else res_q_ff <= 32'(q_full);
               pmu_ff <= mu_ff; plag_ff <= it_ff.lagged;
               st_ff <= S_OUT;
            end
            S_OUT: if (out_ready) st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_div: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_DIV && cnt_ff == 7'd95 |=> st_ff == S_FIN) else $error("divider overrun");
   a_nodiv: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_AB && !it_ff.diff_valid |=> st_ff == S_FIN) else $error("bad skip");
   a_state: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_FIN |=> pmu_ff == $past(mu_ff)) else $error("state not updated");
`endif
endmodule

### src/exp_mean_quasi_difference_core.sv
// Top level of the exponential-mean quasi-difference core.
// Depends on emqd_pkg, emqd_if, emqd_front, emqd_queue, emqd_back.
//
//  channel | direction | beat
//  req     | in        | period, outcome, lagged_outcome, cov_a..cov_d
//  rsp     | out       | mean_factor, quasi_diff, diff_valid, saturated
//  csr     | in (APB)  | registers 0..5 at 4*i
//
// An item passes the front one covariate at a time (k covariates used) and then the
// back, where only an item with a difference runs the 96-step restoring divider.
// The 2-entry queue overlaps the two halves.
// Reset is synchronous, active high; registers and previous-item state clear.
// A stalled rsp holds the back end; the front and queue still take beats until both are full.
module exp_mean_quasi_difference_core import emqd_pkg::*; #(
   parameter int MAX_COVARIATES = MaxCovariatesDef,
   parameter int FRAC_BITS = FracBitsDef
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [15:0] req_period,
   input  logic signed [31:0] req_outcome,
   input  logic signed [31:0] req_lagged_outcome,
   input  logic signed [31:0] req_cov_a,
   input  logic signed [31:0] req_cov_b,
   input  logic signed [31:0] req_cov_c,
   input  logic signed [31:0] req_cov_d,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [31:0] rsp_mean_factor,
   output logic signed [31:0] rsp_quasi_diff,
   output logic rsp_diff_valid,
   output logic rsp_saturated,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [4:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   logic signed [31:0] rho_ff;
   logic [NumCoef-1:0][31:0] coef_ff;
   logic [2:0] used_ff;
   logic [2:0] ridx;
   logic wr;

   emqd_if #(.payload_type(item_type)) fq (.clock(clock));
   emqd_if #(.payload_type(item_type)) qb (.clock(clock));

   assign pready = 1'b1;
   assign ridx = paddr[4:2];
   assign wr = psel && penable && pwrite;

   // register file: write on the access phase, ignore unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         rho_ff <= '0; coef_ff <= '0; used_ff <= '0;
      end else if (wr) begin
         case (ridx)
            RegFeedback: rho_ff <= pwdata;
            RegCoefA:    coef_ff[0] <= pwdata;
            RegCoefB:    coef_ff[1] <= pwdata;
            RegCoefC:    coef_ff[2] <= pwdata;
            RegCoefD:    coef_ff[3] <= pwdata;
            RegCovUsed:  used_ff <= pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ridx)
         RegFeedback: prdata = rho_ff;
         RegCoefA:    prdata = coef_ff[0];
         RegCoefB:    prdata = coef_ff[1];
         RegCoefC:    prdata = coef_ff[2];
         RegCoefD:    prdata = coef_ff[3];
         RegCovUsed:  prdata = {29'b0, used_ff};
         default:     prdata = '0;
      endcase
   end

   emqd_front #(.MAX_COVARIATES(MAX_COVARIATES), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready), .in_period(req_period),
      .in_outcome(req_outcome), .in_lagged(req_lagged_outcome),
      .in_cov({req_cov_d, req_cov_c, req_cov_b, req_cov_a}),
      .coef(coef_ff), .cov_used(used_ff),
      .q_valid(fq.valid), .q_ready(fq.ready), .q_item(fq.data));

   emqd_queue u_queue (
      .clock, .reset,
      .in_valid(fq.valid), .in_ready(fq.ready), .in_item(fq.data),
      .out_valid(qb.valid), .out_ready(qb.ready), .out_item(qb.data));

   emqd_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset,
      .in_valid(qb.valid), .in_ready(qb.ready), .in_item(qb.data), .rho(rho_ff),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_mu(rsp_mean_factor),
      .out_q(rsp_quasi_diff), .out_dv(rsp_diff_valid), .out_sat(rsp_saturated));

`ifndef NO_ASSERTIONS
   a_dv: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_diff_valid |-> rsp_quasi_diff == '0) else $error("q without diff");
   a_used: assert property (@(posedge clock) disable iff (reset)
      used_ff <= 3'd7) else $error("count reg corrupt");
   a_mu: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mean_factor == 32'hFFFF_FFFF |-> rsp_saturated)
      else $error("mu top without flag");
`endif
endmodule

### test/exp_mean_quasi_difference_core_tb.sv
// Testbench for exp_mean_quasi_difference_core: random and directed panel rows
// checked beat by beat against a predictor written in place.
// Depends on emqd_pkg, emqd_if and the core itself.
`timescale 1ns / 1ps

module exp_mean_quasi_difference_core_tb;
   import emqd_pkg::*;

   typedef struct packed {
      logic [15:0]        period;
      logic signed [31:0] outcome;
      logic signed [31:0] lagged_outcome;
      logic signed [31:0] cov_a;
      logic signed [31:0] cov_b;
      logic signed [31:0] cov_c;
      logic signed [31:0] cov_d;
   } obs_type;

   typedef struct packed {
      logic [31:0]        mean_factor;
      logic signed [31:0] quasi_diff;
      logic               diff_valid;
      logic               saturated;
   } res_type;

   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   emqd_if #(.payload_type(obs_type)) req_ch (clock);
   emqd_if #(.payload_type(res_type)) rsp_ch (clock);

   // Predictor copy of the registers and the previous-row state.
   logic signed [31:0] rho_q;
   logic signed [31:0] coef_q [4];
   logic [2:0]         cov_used_q;
   logic [31:0]        last_mu;
   logic [31:0]        last_lag;

   res_type expected_rows[$];
   int   mismatches;
   bit   steady;      // no random idling while set
   int   hold_cycles; // receiver hold-off, counted down below

   exp_mean_quasi_difference_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready),
      .req_period(req_ch.data.period), .req_outcome(req_ch.data.outcome),
      .req_lagged_outcome(req_ch.data.lagged_outcome),
      .req_cov_a(req_ch.data.cov_a), .req_cov_b(req_ch.data.cov_b),
      .req_cov_c(req_ch.data.cov_c), .req_cov_d(req_ch.data.cov_d),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
      .rsp_mean_factor(rsp_ch.data.mean_factor),
      .rsp_quasi_diff(rsp_ch.data.quasi_diff),
      .rsp_diff_valid(rsp_ch.data.diff_valid),
      .rsp_saturated(rsp_ch.data.saturated),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   // exp of a Q16.16 index: base-2 split, Taylor series on the fraction in Q30.
   function automatic logic [31:0] exp_fixed(longint x, inout bit sat);
      longint lim, y, n, s;
      longint unsigned f, r, term, e, v;
      lim = longint'(32) <<< 16;
      if (x > lim) x = lim;
      if (x < -lim) x = -lim;
      y = x * 64'sd1549082005;
      n = y >>> 46;
      f = longint'(y - (n <<< 46)) >> 16;
      r = (f * 64'd744261118) >> 30;
      term = 64'd1073741824;
      e = term;
      for (int k = 1; k <= 12; k++) begin
         term = ((term * r) >> 30) / k;
         e += term;
      end
      s = n + 16 - 30;
      if (s >= 0) begin
         if (s > 32) begin
            sat = 1'b1;
            return 32'hFFFF_FFFF;
         end
         v = e << s;
         if (v > 64'hFFFF_FFFF) begin
            sat = 1'b1;
            return 32'hFFFF_FFFF;
         end
         return v[31:0];
      end
      if (-s >= 63) return 32'd0;
      return 32'(e >> (-s));
   endfunction

   // Work out the row's result and advance the previous-row state.
   function automatic res_type predict_row(obs_type o);
      res_type res;
      bit     sat;
      longint x, a, b, term, q;
      longint cov [4];
      longint unsigned mag, qm;
      logic [127:0] prod, quo;
      int     used;
      logic [31:0] mu, div;
      cov[0] = o.cov_a; cov[1] = o.cov_b; cov[2] = o.cov_c; cov[3] = o.cov_d;
      sat = 1'b0;
      x = 0;
      q = 0;
      used = (cov_used_q > 4) ? 4 : int'(cov_used_q);
      for (int k = 0; k < used; k++)
         x += (longint'(coef_q[k]) * cov[k]) >>> 16;
      mu = exp_fixed(x, sat);
      res.diff_valid = (o.period > FirstPeriod);
      if (res.diff_valid) begin
         a = (longint'(o.outcome) * 65536 - longint'(rho_q) * o.lagged_outcome) >>> 16;
         b = (longint'(o.lagged_outcome) * 65536
              - longint'(rho_q) * longint'($signed(last_lag))) >>> 16;
         div = (mu != 0) ? mu : 32'd1;
         mag = (a < 0) ? longint'(-a) : longint'(a);
         prod = {64'd0, mag} * {96'd0, last_mu};
         quo = prod / {96'd0, div};
         qm = (quo >= (128'd1 << 62)) ? (64'd1 << 62) : quo[63:0];
         term = (a < 0) ? -longint'(qm) : longint'(qm);
         q = term - b;
         if (q > 64'sd2147483647) begin
            q = 64'sd2147483647;
            sat = 1'b1;
         end
         if (q < -64'sd2147483648) begin
            q = -64'sd2147483648;
            sat = 1'b1;
         end
      end
      last_mu = mu;
      last_lag = o.lagged_outcome;
      res.mean_factor = mu;
      res.quasi_diff = q[31:0];
      res.saturated = sat;
      return res;
   endfunction

   // Random Q16.16 value of random magnitude, so every bit toggles.
   function automatic logic [31:0] rand_fix();
      return $signed($urandom) >>> $urandom_range(0, 31);
   endfunction

   // Random value with at most a few integer bits, keeps mu in range.
   function automatic logic [31:0] rand_mild();
      return $signed($urandom) >>> $urandom_range(12, 31);
   endfunction

   // Predict on every accepted request beat.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         expected_rows.push_back(predict_row(req_ch.data));
   end

   // Check every accepted result beat against the oldest prediction.
   always @(posedge clock) begin
      res_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rows.size() == 0) begin
            $error("result beat with no row outstanding");
            mismatches++;
         end else begin
            want = expected_rows.pop_front();
            if (rsp_ch.data.mean_factor !== want.mean_factor) begin
               $error("mean_factor expected %h got %h", want.mean_factor,
                      rsp_ch.data.mean_factor);
               mismatches++;
            end
            if (rsp_ch.data.quasi_diff !== want.quasi_diff) begin
               $error("quasi_diff expected %h got %h", want.quasi_diff,
                      rsp_ch.data.quasi_diff);
               mismatches++;
            end
            if (rsp_ch.data.diff_valid !== want.diff_valid) begin
               $error("diff_valid expected %b got %b", want.diff_valid,
                      rsp_ch.data.diff_valid);
               mismatches++;
            end
            if (rsp_ch.data.saturated !== want.saturated) begin
               $error("saturated expected %b got %b", want.saturated,
                      rsp_ch.data.saturated);
               mismatches++;
            end
         end
      end
   end

   // Receiver: hold off while the counter runs, else idle at random unless steady is set.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= steady || ($urandom_range(99) >= 23);
      end
   end

   // Register write over the config port; call at a falling edge.
   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         RegFeedback: rho_q = value;
         RegCoefA:    coef_q[0] = value;
         RegCoefB:    coef_q[1] = value;
         RegCoefC:    coef_q[2] = value;
         RegCoefD:    coef_q[3] = value;
         RegCovUsed:  cov_used_q = value[2:0];
         default: ;
      endcase
   endtask

   // Send one row; entered and left at a falling edge.
   task automatic send_row(obs_type o);
      while (!steady && $urandom_range(99) < 23) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= o;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drain results, then let the core settle before a register change.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      wait (expected_rows.size() == 0);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_config(logic [31:0] rho, logic [31:0] ca, logic [31:0] cb,
                             logic [31:0] cc, logic [31:0] cd, logic [2:0] used);
      write_reg(RegFeedback, rho);
      write_reg(RegCoefA, ca);
      write_reg(RegCoefB, cb);
      write_reg(RegCoefC, cc);
      write_reg(RegCoefD, cd);
      write_reg(RegCovUsed, used);
   endtask

   function automatic obs_type make_row(logic [15:0] period, logic [31:0] y, logic [31:0] ly,
                                        logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                                        logic [31:0] c3);
      obs_type o;
      o.period = period; o.outcome = y; o.lagged_outcome = ly;
      o.cov_a = c0; o.cov_b = c1; o.cov_c = c2; o.cov_d = c3;
      return o;
   endfunction

   // Field extremes, no covariates, tiny and saturated mu, clamped q.
   task automatic test_directed();
      // no covariates in use: mu exactly one
      send_row(make_row(16'd0, 32'h7FFF_FFFF, 32'h8000_0000, '1, '1, '1, '1));
      send_row(make_row(16'd2, 32'h0001_0000, 32'h0002_0000, 0, 0, 0, 0));
      send_row(make_row(16'd3, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0));
      send_row(make_row(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0));
      drain();
      // large feedback, more covariates than exist
      set_config(32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
                 32'h0002_0000, 3'd7);
      // mu saturates high, then underflows to zero (divisor clamp)
      send_row(make_row(16'd3, 32'h0010_0000, 32'h0001_0000, 32'h0040_0000, 0, 0, 0));
      send_row(make_row(16'd4, 32'h0010_0000, 32'h0001_0000, 32'hFFC0_0000, 0, 0, 0));
      send_row(make_row(16'd5, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFC0_0000, 0, 0, 0));
      send_row(make_row(16'd6, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0010_0000, 0, 0, 0));
      send_row(make_row(16'd1, 32'h0003_0000, 32'h0002_0000, 0, 32'h0001_0000, 0, 0));
      send_row(make_row(16'd7, 32'h0003_0000, 32'h0002_0000, 0, 32'h0001_0000,
                        32'h0001_0000, 32'h0001_0000));
      drain();
      set_config(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 3'd4);
      send_row(make_row(16'd3, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
      send_row(make_row(16'd4, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0));
      send_row(make_row(16'd5, 32'h8000_0000, 32'h8000_0000, 1, 1, 1, 1));
      drain();
      for (int u = 1; u <= 4; u++) begin
         set_config(32'h0000_8000, 32'h0000_4000, 32'hFFFF_C000, 32'h0000_2000,
                    32'h0001_0000, u[2:0]);
         send_row(make_row(16'd3, 32'h0005_0000, 32'h0004_0000, 32'h0002_0000,
                           32'h0003_0000, 32'hFFFF_0000, 32'h0001_8000));
         drain();
      end
   endtask

   // Random sorted panels: units start at period 2 and run on; some noise.
   task automatic test_random_panels(int rows, bit wild);
      int per;
      obs_type o;
      per = 2;
      for (int i = 0; i < rows; i++) begin
         if ($urandom_range(99) < 15) per = 2;
         o.period = ($urandom_range(99) < 10) ? 16'($urandom) : 16'(per);
         o.outcome = wild ? rand_fix() : rand_mild();
         o.lagged_outcome = wild ? rand_fix() : rand_mild();
         o.cov_a = wild ? rand_fix() : rand_mild();
         o.cov_b = wild ? rand_fix() : rand_mild();
         o.cov_c = wild ? rand_fix() : rand_mild();
         o.cov_d = wild ? rand_fix() : rand_mild();
         send_row(o);
         per++;
      end
      drain();
   endtask

   // Hold the receiver back long enough for the core to stall its input.
   task automatic test_backpressure();
      obs_type o;
      hold_cycles = 800;
      for (int i = 0; i < 12; i++) begin
         o = make_row(16'(i + 2), rand_mild(), rand_mild(), rand_mild(), rand_mild(),
                      rand_mild(), rand_mild());
         send_row(o);
      end
      drain();
   endtask

   initial begin
      mismatches = 0;
      steady = 1'b0;
      hold_cycles = 0;
      reset = 1'b1;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      rho_q = 0; coef_q = '{0, 0, 0, 0}; cov_used_q = 0;
      last_mu = 0; last_lag = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      set_config(rand_mild(), rand_mild(), rand_mild(), rand_mild(), rand_mild(), 3'd4);
      test_random_panels(120, 1'b0);
      // stretch with no idling on either side
      steady = 1'b1;
      test_random_panels(60, 1'b0);
      steady = 1'b0;
      set_config(rand_fix(), rand_mild(), rand_mild(), rand_mild(), rand_mild(),
                 3'($urandom_range(0, 7)));
      test_random_panels(100, 1'b0);
      set_config(rand_fix(), rand_fix(), rand_fix(), rand_fix(), rand_fix(),
                 3'($urandom_range(0, 7)));
      test_random_panels(100, 1'b1);
      test_backpressure();

      repeat (200) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Give up well past the slowest legitimate run.
   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

endmodule
